// ===== rtl/dlps_pkg.sv =====
package dlps_pkg;

    // opcode of an input beat
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // line style register codes
    localparam logic [2:0] STYLE_NONE     = 3'd0;
    localparam logic [2:0] STYLE_SOLID    = 3'd1;
    localparam logic [2:0] STYLE_DOTTED   = 3'd2;
    localparam logic [2:0] STYLE_DASHED   = 3'd3;
    localparam logic [2:0] STYLE_DASH_DOT = 3'd4;

    // pattern phase runs 0..PHASE_LAST, then wraps
    localparam logic [3:0] PHASE_LAST = 4'd11;

    // decoded command flags carried through the queue
    typedef struct packed {
        logic is_start;
        logic zero_len;
        logic neg_x;
        logic neg_y;
    } cmd_flags_t;

    localparam int CMD_FLAGS_W = $bits(cmd_flags_t);

    typedef enum logic {
        BK_RUN,
        BK_DIVIDE
    } back_state_t;

    function automatic logic style_plots(input logic [2:0] style, input logic [3:0] phase);
        logic hit;
        hit = 1'b0;
        case (style)
            STYLE_SOLID:    hit = 1'b1;
            STYLE_DOTTED:   hit = ~phase[0];
            STYLE_DASHED:   hit = (phase < 4'd4) || ((phase >= 4'd6) && (phase < 4'd10));
            STYLE_DASH_DOT: hit = (phase < 4'd6) || (phase == 4'd9);
            default:        hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

// ===== rtl/dda_line_pattern_stepper_unit.sv =====
// dda line rasterizer with line styles
// input stream: one beat per command; s_tuser is the opcode (start a line or
//   advance one step), s_tdata carries both endpoints for a start
// output stream: one beat per input beat with the current point in m_tdata,
//   the plot flag in m_tuser and line_done in m_tlast
// cfg_we / cfg_wdata write the line style register; the user must write it only
//   while the block idles; the block itself leaves this unenforced
// a command is written into the queue in the cycle it is taken; its result beat
//   is registered in the output register once the back end pops it
// a step beat is handled by the accumulator adds once the output register is free
//   and no division runs; a start beat of a line with nonzero length holds the
//   back end while the shared bit-serial divider forms both per-step increments
//   (one quotient bit a cycle); the start point itself goes out at once
// a two-entry queue sits between the decode front and the stepping back end,
//   so input beats keep coming while a result beat waits on m_tready
// reset: synchronous, active low; line style returns to solid, no line is
//   active, the queue and the output register are emptied
// stall: with m_tready low the result beat holds, the queue fills, then
//   s_tready drops
module dda_line_pattern_stepper_unit #(
    parameter int  COORD_BITS = 11,
    parameter int  FRAC_BITS  = 16,
    localparam int S_DATA_W   = ((4 * COORD_BITS + 7) / 8) * 8,
    localparam int M_DATA_W   = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_we,
    input  logic [2:0]          cfg_wdata,   // line_style

    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,     // start_x, start_y, end_x, end_y, zero pad
    input  logic                s_tuser,     // opcode

    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,     // point_x, point_y, zero pad
    output logic                m_tuser,     // plot
    output logic                m_tlast      // line_done
);
    import dlps_pkg::*;

    // queue entry: flags over start point, magnitudes and step count
    localparam int ENTRY_W = CMD_FLAGS_W + 5 * COORD_BITS;

    // decoded command from the front
    cmd_flags_t            f_flags;
    logic [COORD_BITS-1:0] f_start_x, f_start_y, f_abs_dx, f_abs_dy, f_steps;

    // command at the head of the queue
    logic [ENTRY_W-1:0]    q_entry;
    logic                  q_valid, q_pop, q_full;
    cmd_flags_t            q_flags;
    logic [COORD_BITS-1:0] q_start_x, q_start_y, q_abs_dx, q_abs_dy, q_steps;

    logic [COORD_BITS-1:0] pt_x, pt_y;

    // front: differences, magnitudes, step count and kind of command
    dlps_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .op     (s_tuser),
        .coords (s_tdata[4*COORD_BITS-1:0]),
        .flags  (f_flags),
        .start_x(f_start_x),
        .start_y(f_start_y),
        .abs_dx (f_abs_dx),
        .abs_dy (f_abs_dy),
        .steps  (f_steps)
    );

    // decouples the front from the stepping back end
    dlps_fifo #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (s_tvalid),
        .wr_data  ({f_flags, f_start_x, f_start_y, f_abs_dx, f_abs_dy, f_steps}),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_data  (q_entry),
        .not_empty(q_valid)
    );

    assign s_tready = !q_full;

    assign q_flags   = cmd_flags_t'(q_entry[ENTRY_W-1:5*COORD_BITS]);
    assign q_start_x = q_entry[5*COORD_BITS-1:4*COORD_BITS];
    assign q_start_y = q_entry[4*COORD_BITS-1:3*COORD_BITS];
    assign q_abs_dx  = q_entry[3*COORD_BITS-1:2*COORD_BITS];
    assign q_abs_dy  = q_entry[2*COORD_BITS-1:COORD_BITS];
    assign q_steps   = q_entry[COORD_BITS-1:0];

    // back: accumulators, pattern phase, divider and output register
    dlps_back #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_flags  (q_flags),
        .q_start_x(q_start_x),
        .q_start_y(q_start_y),
        .q_abs_dx (q_abs_dx),
        .q_abs_dy (q_abs_dy),
        .q_steps  (q_steps),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_plot (m_tuser),
        .out_x    (pt_x),
        .out_y    (pt_y),
        .out_done (m_tlast)
    );

    // pack the point, pad to whole bytes
    assign m_tdata = {{(M_DATA_W - 2*COORD_BITS){1'b0}}, pt_y, pt_x};

endmodule

// ===== rtl/dlps_front.sv =====
module dlps_front #(
    parameter int COORD_BITS = 11
) (
    input  logic                    op,
    input  logic [4*COORD_BITS-1:0] coords,
    output dlps_pkg::cmd_flags_t    flags,
    output logic [COORD_BITS-1:0]   start_x,
    output logic [COORD_BITS-1:0]   start_y,
    output logic [COORD_BITS-1:0]   abs_dx,
    output logic [COORD_BITS-1:0]   abs_dy,
    output logic [COORD_BITS-1:0]   steps
);
    import dlps_pkg::*;

    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_mag;
    logic [COORD_BITS:0]   dy_mag;

    assign start_x = coords[COORD_BITS-1:0];
    assign start_y = coords[2*COORD_BITS-1:COORD_BITS];
    assign end_x   = coords[3*COORD_BITS-1:2*COORD_BITS];
    assign end_y   = coords[4*COORD_BITS-1:3*COORD_BITS];

    // one extra bit holds the full span of a difference
    assign dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};

    assign dx_mag = dx[COORD_BITS] ? -dx : dx;
    assign dy_mag = dy[COORD_BITS] ? -dy : dy;

    assign abs_dx = dx_mag[COORD_BITS-1:0];
    assign abs_dy = dy_mag[COORD_BITS-1:0];
    assign steps  = (abs_dx > abs_dy) ? abs_dx : abs_dy;

    always_comb begin
        flags.is_start = (op == OP_START);
        flags.zero_len = (steps == '0);
        flags.neg_x    = dx[COORD_BITS];
        flags.neg_y    = dy[COORD_BITS];
    end

endmodule

// ===== rtl/dlps_fifo.sv =====
module dlps_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/dlps_div.sv =====
module dlps_div #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] divisor,
    input  logic [COORD_BITS-1:0] mag_x,
    input  logic [COORD_BITS-1:0] mag_y,
    output logic                  done,
    output logic [FRAC_BITS:0]    quo_x,
    output logic [FRAC_BITS:0]    quo_y
);
    localparam int NUM_W = COORD_BITS + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic [COORD_BITS-1:0] div_reg;
    logic [COORD_BITS-1:0] rem_x_reg, rem_y_reg;
    logic [FRAC_BITS:0]    lo_x_reg, lo_y_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [NUM_W-1:0]      num_x, num_y, half;
    logic [COORD_BITS:0]   part_x, part_y, diff_x, diff_y;
    logic                  ge_x, ge_y;

    // numerator |d| * 2^frac + steps/2, rounds the quotient to nearest
    assign half  = {{(FRAC_BITS+2){1'b0}}, divisor[COORD_BITS-1:1]};
    assign num_x = {1'b0, mag_x, {FRAC_BITS{1'b0}}} + half;
    assign num_y = {1'b0, mag_y, {FRAC_BITS{1'b0}}} + half;

    // one quotient bit per cycle for both axes
    assign part_x = {rem_x_reg, lo_x_reg[FRAC_BITS]};
    assign part_y = {rem_y_reg, lo_y_reg[FRAC_BITS]};
    assign diff_x = part_x - {1'b0, div_reg};
    assign diff_y = part_y - {1'b0, div_reg};
    assign ge_x   = (part_x >= {1'b0, div_reg});
    assign ge_y   = (part_y >= {1'b0, div_reg});

    assign done  = done_reg;
    assign quo_x = lo_x_reg;
    assign quo_y = lo_y_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg   <= divisor;
            rem_x_reg <= num_x[NUM_W-1:FRAC_BITS+1];
            rem_y_reg <= num_y[NUM_W-1:FRAC_BITS+1];
            lo_x_reg  <= num_x[FRAC_BITS:0];
            lo_y_reg  <= num_y[FRAC_BITS:0];
        end else if (busy_reg) begin
            rem_x_reg <= ge_x ? diff_x[COORD_BITS-1:0] : part_x[COORD_BITS-1:0];
            rem_y_reg <= ge_y ? diff_y[COORD_BITS-1:0] : part_y[COORD_BITS-1:0];
            lo_x_reg  <= {lo_x_reg[FRAC_BITS-1:0], ge_x};
            lo_y_reg  <= {lo_y_reg[FRAC_BITS-1:0], ge_y};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(FRAC_BITS + 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/dlps_back.sv =====
module dlps_back #(
    parameter int COORD_BITS = 11,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_wdata,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  dlps_pkg::cmd_flags_t  q_flags,
    input  logic [COORD_BITS-1:0] q_start_x,
    input  logic [COORD_BITS-1:0] q_start_y,
    input  logic [COORD_BITS-1:0] q_abs_dx,
    input  logic [COORD_BITS-1:0] q_abs_dy,
    input  logic [COORD_BITS-1:0] q_steps,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_plot,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic                  out_done
);
    import dlps_pkg::*;

    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;

    back_state_t              state_reg, state_next;
    logic [2:0]               style_reg;
    logic signed [ACC_W-1:0]  x_acc_reg, x_acc_next, y_acc_reg, y_acc_next;
    logic signed [STEP_W-1:0] x_step_reg, x_step_next, y_step_reg, y_step_next;
    logic [COORD_BITS-1:0]    left_reg, left_next;
    logic [3:0]               phase_reg, phase_next;
    logic                     neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic                     valid_reg, valid_next;
    logic                     plot_reg, plot_next, done_reg, done_next;
    logic [COORD_BITS-1:0]    px_reg, px_next, py_reg, py_next;

    logic                     out_free;
    logic                     div_start, div_done;
    logic [FRAC_BITS:0]       quo_x, quo_y;
    logic [STEP_W-1:0]        mag_x, mag_y;
    logic signed [ACC_W-1:0]  x_sum, y_sum;

    dlps_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (div_start),
        .divisor(q_steps),
        .mag_x  (q_abs_dx),
        .mag_y  (q_abs_dy),
        .done   (div_done),
        .quo_x  (quo_x),
        .quo_y  (quo_y)
    );

    assign mag_x = {1'b0, quo_x};
    assign mag_y = {1'b0, quo_y};

    // accumulators carry a +1/2 bias so the integer part is the rounded point
    assign x_sum = x_acc_reg + {{(COORD_BITS-1){x_step_reg[STEP_W-1]}}, x_step_reg};
    assign y_sum = y_acc_reg + {{(COORD_BITS-1){y_step_reg[STEP_W-1]}}, y_step_reg};

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_plot  = plot_reg;
    assign out_x     = px_reg;
    assign out_y     = py_reg;
    assign out_done  = done_reg;

    always_comb begin
        state_next  = state_reg;
        x_acc_next  = x_acc_reg;
        y_acc_next  = y_acc_reg;
        x_step_next = x_step_reg;
        y_step_next = y_step_reg;
        left_next   = left_reg;
        phase_next  = phase_reg;
        neg_x_next  = neg_x_reg;
        neg_y_next  = neg_y_reg;
        plot_next   = plot_reg;
        done_next   = done_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        q_pop       = 1'b0;
        div_start   = 1'b0;

        unique case (state_reg)
            BK_RUN: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_flags.is_start) begin
                        x_acc_next = {q_start_x[COORD_BITS-1], q_start_x, 1'b1,
                                      {(FRAC_BITS-1){1'b0}}};
                        y_acc_next = {q_start_y[COORD_BITS-1], q_start_y, 1'b1,
                                      {(FRAC_BITS-1){1'b0}}};
                        left_next  = q_steps;
                        phase_next = '0;
                        neg_x_next = q_flags.neg_x;
                        neg_y_next = q_flags.neg_y;
                        plot_next  = 1'b1;
                        px_next    = q_start_x;
                        py_next    = q_start_y;
                        done_next  = q_flags.zero_len;
                        if (!q_flags.zero_len) begin
                            div_start  = 1'b1;
                            state_next = BK_DIVIDE;
                        end
                    end else if (left_reg == '0) begin
                        plot_next = 1'b0;
                        px_next   = '0;
                        py_next   = '0;
                        done_next = 1'b1;
                    end else begin
                        x_acc_next = x_sum;
                        y_acc_next = y_sum;
                        left_next  = left_reg - COORD_BITS'(1);
                        phase_next = (phase_reg == PHASE_LAST) ? 4'd0 : phase_reg + 4'd1;
                        plot_next  = style_plots(style_reg, phase_reg);
                        px_next    = x_sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
                        py_next    = y_sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
                        done_next  = (left_reg == COORD_BITS'(1));
                    end
                end
            end
            BK_DIVIDE: begin
                if (div_done) begin
                    x_step_next = neg_x_reg ? -mag_x : mag_x;
                    y_step_next = neg_y_reg ? -mag_y : mag_y;
                    state_next  = BK_RUN;
                end
            end
            default: begin
                state_next = BK_RUN;
            end
        endcase

        valid_next = q_pop ? 1'b1 : (out_ready ? 1'b0 : valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_RUN;
            style_reg <= STYLE_SOLID;
            left_reg  <= '0;
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                style_reg <= cfg_wdata;
            end
            left_reg  <= left_next;
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_acc_reg  <= x_acc_next;
        y_acc_reg  <= y_acc_next;
        x_step_reg <= x_step_next;
        y_step_reg <= y_step_next;
        neg_x_reg  <= neg_x_next;
        neg_y_reg  <= neg_y_next;
        plot_reg   <= plot_next;
        done_reg   <= done_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
    end

endmodule

// ===== tb/dda_line_pattern_stepper_unit_tb.sv =====
module dda_line_pattern_stepper_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlps_pkg::*;

    localparam int COORD_BITS = 11;
    localparam int FRAC_BITS  = 16;
    localparam int S_W        = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_W        = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam longint FIX_ONE = longint'(1) << FRAC_BITS;
    localparam int COORD_MAX  = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN  = -(1 << (COORD_BITS - 1));

    // style code with no pattern behind it, nothing but the start point plots
    localparam logic [2:0] STYLE_UNUSED = 3'd7;

    // cycles the divider may still run after the last point beat of a phase
    localparam int SETTLE = 2 * (FRAC_BITS + 3);
    // watchdog limit, with plenty of room over the slowest run
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 60;

    typedef struct {
        logic                         op;
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
    } line_cmd_t;

    typedef struct {
        logic                  plot;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  done;
    } point_beat_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic           cfg_we    = 1'b0;
    logic [2:0]     cfg_wdata = '0;

    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata  = '0;   // start_x, start_y, end_x, end_y, zero pad
    logic           s_tuser  = 1'b0; // opcode

    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;         // point_x, point_y, zero pad
    logic           m_tuser;         // plot
    logic           m_tlast;         // line_done

    dda_line_pattern_stepper_unit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // commands waiting for the driver, points waiting for the monitor
    line_cmd_t   cmd_q[$];
    point_beat_t point_q[$];

    int errors         = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int cycle_cnt      = 0;

    // shadow of the rasterizer state
    logic [2:0] cur_style = STYLE_SOLID;
    longint     x_acc, y_acc, x_inc, y_inc;
    int         steps_rem, phase_idx;

    // per-step increment: |d| * 2^frac / steps, halves away from zero
    function automatic longint step_increment(longint d, longint n);
        longint q;
        q = ((d < 0 ? -d : d) * FIX_ONE + n / 2) / n;
        return d < 0 ? -q : q;
    endfunction

    // floor(acc + 0.5), wrapped to the coordinate width
    function automatic logic [COORD_BITS-1:0] round_coord(longint acc);
        longint t;
        t = (acc + FIX_ONE / 2) >>> FRAC_BITS;
        return t[COORD_BITS-1:0];
    endfunction

    function automatic logic style_draws(logic [2:0] style, int i);
        case (style)
            STYLE_SOLID:    return 1'b1;
            STYLE_DOTTED:   return (i % 2) == 0;
            STYLE_DASHED:   return (i % 6) < 4;
            STYLE_DASH_DOT: return (i % 12) < 6 || (i % 12) == 9;
            default:        return 1'b0;
        endcase
    endfunction

    // next point of the line for one accepted command, updates the shadow state
    function automatic point_beat_t rasterize_cmd(line_cmd_t c);
        point_beat_t r;
        longint sx, sy, dx, dy, adx, ady, n;
        if (c.op == OP_START) begin
            sx  = c.sx;
            sy  = c.sy;
            dx  = longint'(c.ex) - sx;
            dy  = longint'(c.ey) - sy;
            adx = dx < 0 ? -dx : dx;
            ady = dy < 0 ? -dy : dy;
            n   = adx > ady ? adx : ady;
            x_acc = sx * FIX_ONE;
            y_acc = sy * FIX_ONE;
            x_inc = n > 0 ? step_increment(dx, n) : 0;
            y_inc = n > 0 ? step_increment(dy, n) : 0;
            steps_rem = int'(n);
            phase_idx = 0;
            // start point always plots
            r.plot = 1'b1;
            r.px   = c.sx;
            r.py   = c.sy;
            r.done = (steps_rem == 0);
        end else if (steps_rem == 0) begin
            // no line running, state stays as it is
            r.plot = 1'b0;
            r.px   = '0;
            r.py   = '0;
            r.done = 1'b1;
        end else begin
            x_acc = x_acc + x_inc;
            y_acc = y_acc + y_inc;
            steps_rem = steps_rem - 1;
            r.plot = style_draws(cur_style, phase_idx);
            phase_idx = (phase_idx + 1) % 12;
            r.px   = round_coord(x_acc);
            r.py   = round_coord(y_acc);
            r.done = (steps_rem == 0);
        end
        return r;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(2 * COORD_MAX + 1)) + COORD_MIN;
    endfunction

    function automatic int clamp_coord(int v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < COORD_MIN) return COORD_MIN;
        return v;
    endfunction

    task automatic push_start(input int sx, input int sy, input int ex, input int ey);
        line_cmd_t c;
        c.op = OP_START;
        c.sx = sx[COORD_BITS-1:0];
        c.sy = sy[COORD_BITS-1:0];
        c.ex = ex[COORD_BITS-1:0];
        c.ey = ey[COORD_BITS-1:0];
        cmd_q.push_back(c);
    endtask

    // step beats carry random endpoint bits, which the block must ignore
    task automatic push_step();
        line_cmd_t c;
        c.op = OP_STEP;
        c.sx = COORD_BITS'($urandom);
        c.sy = COORD_BITS'($urandom);
        c.ex = COORD_BITS'($urandom);
        c.ey = COORD_BITS'($urandom);
        cmd_q.push_back(c);
    endtask

    // random lines, mostly complete short ones so the patterns wrap
    task automatic fill_phase(input int target);
        int made, kind, span, sx, sy, ex, ey, adx, ady, n, k;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(99);
            sx = rand_coord();
            sy = rand_coord();
            if (kind < 70) begin
                // short line, walked to its end and sometimes a little past
                span = 1 << $urandom_range(5);
                ex = clamp_coord(sx + int'($urandom_range(2 * span)) - span);
                ey = clamp_coord(sy + int'($urandom_range(2 * span)) - span);
                adx = ex > sx ? ex - sx : sx - ex;
                ady = ey > sy ? ey - sy : sy - ey;
                n = adx > ady ? adx : ady;
                if ($urandom_range(9) == 0)
                    k = $urandom_range(n);          // cut off by the next start
                else
                    k = n + $urandom_range(2);
                push_start(sx, sy, ex, ey);
                repeat (k) push_step();
                made += 1 + k;
            end else if (kind < 85) begin
                // any endpoints, only a few steps of it
                k = $urandom_range(4);
                push_start(sx, sy, rand_coord(), rand_coord());
                repeat (k) push_step();
                made += 1 + k;
            end else if (kind < 95) begin
                // stray steps
                k = $urandom_range(1, 3);
                repeat (k) push_step();
                made += k;
            end else begin
                // zero-length line, then a step that finds nothing to do
                push_start(sx, sy, sx, sy);
                push_step();
                made += 2;
            end
        end
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || s_tvalid || point_q.size() != 0)
            @(negedge aclk);
    endtask

    // style register changes only while the block idles
    task automatic write_style(input logic [2:0] style);
        repeat (SETTLE) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= style;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cur_style = style;
    endtask

    // driver: one command per beat, random gaps between beats
    line_cmd_t cur_cmd;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                point_q.push_back(rasterize_cmd(cur_cmd));
            if (!s_tvalid || s_tready) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    cur_cmd = cmd_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= cur_cmd.op;
                    s_tdata  <= {{(S_W - 4 * COORD_BITS){1'b0}},
                                 cur_cmd.ey, cur_cmd.ex, cur_cmd.sy, cur_cmd.sx};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each point beat against the oldest prediction
    always @(posedge aclk) begin
        point_beat_t want, got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.plot = m_tuser;
                got.px   = m_tdata[COORD_BITS-1:0];
                got.py   = m_tdata[2*COORD_BITS-1:COORD_BITS];
                got.done = m_tlast;
                if (point_q.size() == 0) begin
                    $display("%0t: point beat with nothing expected, got x %0d y %0d",
                             $time, $signed(got.px), $signed(got.py));
                    errors++;
                end else begin
                    want = point_q.pop_front();
                    if (got.plot !== want.plot) begin
                        $display("%0t: plot expected %0b got %0b",
                                 $time, want.plot, got.plot);
                        errors++;
                    end
                    if (got.px !== want.px) begin
                        $display("%0t: point_x expected %0d got %0d",
                                 $time, $signed(want.px), $signed(got.px));
                        errors++;
                    end
                    if (got.py !== want.py) begin
                        $display("%0t: point_y expected %0d got %0d",
                                 $time, $signed(want.py), $signed(got.py));
                        errors++;
                    end
                    if (got.done !== want.done) begin
                        $display("%0t: line_done expected %0b got %0b",
                                 $time, want.done, got.done);
                        errors++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d commands and %0d points still pending",
                     $time, cmd_q.size(), point_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // style per random phase: every code, both ends of the range, one unused
    logic [2:0] style_seq [8] = '{STYLE_DOTTED, STYLE_DASHED, STYLE_DASH_DOT, STYLE_NONE,
                                  STYLE_UNUSED, STYLE_SOLID, STYLE_DASH_DOT, STYLE_DASHED};

    initial begin
        x_acc = 0;
        y_acc = 0;
        x_inc = 0;
        y_inc = 0;
        steps_rem = 0;
        phase_idx = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // slow receiver first
        send_gap_pct   = 7;
        recv_stall_pct = 82;

        // directed lines under the reset style
        @(negedge aclk);
        push_step();                                    // no line yet
        push_start(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);   // zero length
        push_step();
        push_start(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);   // longest, both signs
        push_step();
        push_step();
        push_start(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        push_step();
        push_start(0, 0, 3, 1);                         // shallow, walked past its end
        repeat (4) push_step();
        push_start(0, 0, -2, -1);                       // half steps below zero
        repeat (2) push_step();
        push_start(5, -7, 4, 2);                        // steep line
        repeat (3) push_step();
        wait_drained();

        foreach (style_seq[p]) begin
            // swap who idles after the first three phases, none idle at the end
            if (p == 3) begin
                send_gap_pct   = 82;
                recv_stall_pct = 7;
            end else if (p == 6) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            write_style(style_seq[p]);
            @(negedge aclk);
            fill_phase(PHASE_ITEMS);
            wait_drained();
        end

        repeat (SETTLE) @(posedge aclk);
        if (errors == 0 && point_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
